// ===== rtl/core/mvt_pkg.sv =====
// shared types and constants for the 4x4 matrix-vector transform
`default_nettype none

package mvt_pkg;

  localparam int LANES  = 4;
  localparam int COMP_W = 16;                  // q8.8 vector component
  localparam int COEF_W = 16;                  // q4.12 coefficient
  localparam int ROW_W  = LANES * COEF_W;      // one packed matrix row
  localparam int PROD_W = COMP_W + COEF_W;     // q12.20 product
  localparam int SUM_W  = PROD_W + 2;          // sum of four products
  localparam int FRAC   = 12;                  // coefficient fraction bits
  localparam int RND_W  = SUM_W - FRAC;        // rounded, before saturation
  localparam int ADDR_W = 2;

  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (FRAC - 1);
  localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_MIN  = -RND_W'(32768);

  localparam logic [COMP_W-1:0] OUT_MAX = 16'h7fff;
  localparam logic [COMP_W-1:0] OUT_MIN = 16'h8000;

  typedef enum logic [ADDR_W-1:0] {
    REG_ROW_ZERO  = 2'd0,
    REG_ROW_ONE   = 2'd1,
    REG_ROW_TWO   = 2'd2,
    REG_ROW_THREE = 2'd3
  } reg_idx_t;

  localparam logic [ROW_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h1000_0000_0000_0000;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ROW_W-1:0]         row_t;

  // pipeline control between stages
  typedef struct packed {
    logic adv;   // whole pipe moves this cycle
    logic vld;   // upstream stage holds an item
  } stg_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/matrix_vector_transform_4x4_unit.sv =====
// top level of the fixed-point 4x4 matrix times vector transform
//
//  channel  | direction | signals                         | content
//  ---------+-----------+---------------------------------+-------------------------------
//  in_      | slave     | in_tvalid/in_tready/in_tdata    | q8.8 vector x,y,z,w
//  out_     | master    | out_tvalid/out_tready/out_tdata | q8.8 result x,y,z,w; tuser clip
//  cfg_     | write     | cfg_we/cfg_addr/cfg_wdata       | matrix rows 0..3, q4.12 packed
//
// one item per cycle while the output is not stalled; out_tvalid rises once an item has passed
// through four registers: input capture, multiply, sum and round, saturate/output
// the four stages move together; a stalled output holds the whole pipe,
// in_tready follows out_tready whenever the output register is full
// synchronous active-low reset empties the pipe and loads the identity matrix
`default_nettype none

module matrix_vector_transform_4x4_unit import mvt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,    // [15:0] in_x, [31:16] in_y, [47:32] in_z, [63:48] in_w
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,   // [15:0] out_x, [31:16] out_y, [47:32] out_z, [63:48] out_w
  output logic [0:0]             out_tuser,   // [0] clipped
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [ROW_W-1:0]  cfg_wdata
);

  // matrix rows; the user must write them only while the pipe is idle, the block does not enforce it
  row_t rows_r [LANES];

  // pipe advances whenever the output register is empty or being drained
  logic     adv;
  logic     s1_vld_r;
  comp_t    s1_vec_r [LANES];
  logic     s2_vld;
  prod_t    s2_prod [LANES][LANES];
  logic     s3_vld;
  sum_t     s3_sum [LANES];
  comp_t    res [LANES];
  logic     clip;
  stg_ctl_t ctl_mul;
  stg_ctl_t ctl_sum;
  stg_ctl_t ctl_sat;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[REG_ROW_ZERO]  <= ROW_ZERO_RST;
      rows_r[REG_ROW_ONE]   <= ROW_ONE_RST;
      rows_r[REG_ROW_TWO]   <= ROW_TWO_RST;
      rows_r[REG_ROW_THREE] <= ROW_THREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_ZERO:  rows_r[REG_ROW_ZERO]  <= cfg_wdata;
        REG_ROW_ONE:   rows_r[REG_ROW_ONE]   <= cfg_wdata;
        REG_ROW_TWO:   rows_r[REG_ROW_TWO]   <= cfg_wdata;
        REG_ROW_THREE: rows_r[REG_ROW_THREE] <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // stage one: capture the vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < LANES; c++) begin
        s1_vec_r[c] <= in_tdata[c*COMP_W +: COMP_W];
      end
    end
  end

  assign ctl_mul = '{adv: adv, vld: s1_vld_r};
  assign ctl_sum = '{adv: adv, vld: s2_vld};
  assign ctl_sat = '{adv: adv, vld: s3_vld};

  mvt_mul_stage u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_mul),
    .vec_i  (s1_vec_r),
    .rows_i (rows_r),
    .vld_o  (s2_vld),
    .prod_o (s2_prod)
  );

  mvt_sum_stage u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_sum),
    .prod_i (s2_prod),
    .vld_o  (s3_vld),
    .sum_o  (s3_sum)
  );

  mvt_sat_stage u_sat (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_sat),
    .sum_i  (s3_sum),
    .vld_o  (out_tvalid),
    .res_o  (res),
    .clip_o (clip)
  );

  // pack results, x lowest
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      out_tdata[r*COMP_W +: COMP_W] = res[r];
    end
  end

  assign out_tuser = clip;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_mul_stage.sv =====
// stage two: sixteen coefficient by component products
`default_nettype none

module mvt_mul_stage import mvt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire stg_ctl_t ctl_i,
  input  wire comp_t    vec_i [LANES],
  input  wire row_t     rows_i [LANES],
  output logic          vld_o,
  output prod_t         prod_o [LANES][LANES]
);

  logic  vld_r;
  prod_t prod_r   [LANES][LANES];
  prod_t prod_nxt [LANES][LANES];

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int c = 0; c < LANES; c++) begin
        prod_nxt[r][c] = prod_t'($signed(rows_i[r][c*COEF_W +: COEF_W])) * prod_t'(vec_i[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign prod_o = prod_r;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_sum_stage.sv =====
// stage three: per-row sum of products plus rounding bias
`default_nettype none

module mvt_sum_stage import mvt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire stg_ctl_t ctl_i,
  input  wire prod_t    prod_i [LANES][LANES],
  output logic          vld_o,
  output sum_t          sum_o [LANES]
);

  logic vld_r;
  sum_t sum_r   [LANES];
  sum_t sum_nxt [LANES];

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      sum_nxt[r] = SUM_W'(prod_i[r][0]) + SUM_W'(prod_i[r][1])
                 + SUM_W'(prod_i[r][2]) + SUM_W'(prod_i[r][3]) + RND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign vld_o = vld_r;
  assign sum_o = sum_r;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_sat_stage.sv =====
// stage four: scale back to q8.8, saturate, output register
`default_nettype none

module mvt_sat_stage import mvt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire stg_ctl_t ctl_i,
  input  wire sum_t     sum_i [LANES],
  output logic          vld_o,
  output comp_t         res_o [LANES],
  output logic          clip_o
);

  logic  vld_r;
  comp_t res_r   [LANES];
  comp_t res_nxt [LANES];
  logic  clip_r;
  logic  clip_nxt;
  logic signed [RND_W-1:0] scaled [LANES];

  always_comb begin
    clip_nxt = 1'b0;
    for (int r = 0; r < LANES; r++) begin
      scaled[r] = RND_W'(sum_i[r] >>> FRAC);
      if (scaled[r] > SAT_MAX) begin
        res_nxt[r] = comp_t'(OUT_MAX);
        clip_nxt   = 1'b1;
      end else if (scaled[r] < SAT_MIN) begin
        res_nxt[r] = comp_t'(OUT_MIN);
        clip_nxt   = 1'b1;
      end else begin
        res_nxt[r] = scaled[r][COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign res_o  = res_r;
  assign clip_o = clip_r;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_checker.sv =====
// port-level checks for the matrix-vector transform, bound to the top level
`default_nettype none

module mvt_checker import mvt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input is taken whenever the output is free or draining
  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output state");

  // clip flag only with a saturated component
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[15:0] == OUT_MAX || out_tdata[15:0] == OUT_MIN ||
       out_tdata[31:16] == OUT_MAX || out_tdata[31:16] == OUT_MIN ||
       out_tdata[47:32] == OUT_MAX || out_tdata[47:32] == OUT_MIN ||
       out_tdata[63:48] == OUT_MAX || out_tdata[63:48] == OUT_MIN))
    else $error("clipped without a saturated component");

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind matrix_vector_transform_4x4_unit mvt_checker u_mvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_matrix_vector_transform_4x4_unit.sv =====
// self-checking testbench for the fixed-point 4x4 matrix-vector transform unit
module tb_matrix_vector_transform_4x4_unit;
  import mvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // a vector item as it travels on tdata: x in the low 16 bits, w on top
  typedef logic [LANES*COMP_W-1:0] vec_t;

  // one expected result: four saturated lanes plus the clip flag
  typedef struct packed {
    logic clipped;
    vec_t v;
  } xform_result_t;

  typedef enum {MAT_FULL, MAT_UNIT, MAT_EXTREME, MAT_SPARSE} matrix_kind_t;
  typedef enum {VEC_FULL, VEC_SMALL, VEC_EXTREME} vector_kind_t;
  typedef enum {RX_STEADY, RX_CHOPPY, RX_BLOCKED} rx_mode_t;

  localparam int     STALL_LIMIT  = 2000;  // quiet cycles before the watchdog fires
  localparam int     SETTLE_CYCLES = 12;   // settle time after the last result
  localparam int     MSG_LIMIT    = 50;    // mismatch lines printed at most
  localparam longint LANE_MAX     = 32767;
  localparam longint LANE_MIN     = -32768;

  // dut ports; the inputs are known from time zero
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;    // [15:0] x, [31:16] y, [47:32] z, [63:48] w
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;          // [15:0] x, [31:16] y, [47:32] z, [63:48] w
  logic [0:0]        out_tuser;          // [0] clipped
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_addr   = '0;
  logic [ROW_W-1:0]  cfg_wdata  = '0;

  // shadow of the matrix as the dut holds it, starts at the identity
  row_t matrix_rows [LANES] = '{ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, ROW_THREE_RST};

  xform_result_t expected_results [$];
  xform_result_t expected_res;

  string lane_names [LANES] = '{"out_x", "out_y", "out_z", "out_w"};

  int items_accepted  = 0;
  int results_checked = 0;
  int clipped_seen    = 0;
  int matrices_loaded = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;
  int burst_left      = 0;
  bit in_valid_sched  = 1'b0;   // value last scheduled onto in_tvalid

  // receiver stall pattern state
  rx_mode_t rx_mode      = RX_STEADY;
  int       rx_mode_left = 0;
  int       rx_run_left  = 0;
  bit       rx_run_ready = 1'b1;

  matrix_vector_transform_4x4_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // each lane: exact q12.20 dot product, +half then floor shift to q8.8,
  // clamp to 16 bits and flag the clamp
  function automatic xform_result_t transform_vector(input vec_t v);
    xform_result_t res;
    longint        acc;
    longint        rounded;
    res.clipped = 1'b0;
    for (int r = 0; r < LANES; r++) begin
      acc = 0;
      for (int c = 0; c < LANES; c++) begin
        acc += longint'(comp_t'(matrix_rows[r][COEF_W*c +: COEF_W])) *
               longint'(comp_t'(v[COMP_W*c +: COMP_W]));
      end
      // arithmetic shift on a signed longint is a floor, so halves go up
      rounded = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (rounded > LANE_MAX) begin
        rounded     = LANE_MAX;
        res.clipped = 1'b1;
      end else if (rounded < LANE_MIN) begin
        rounded     = LANE_MIN;
        res.clipped = 1'b1;
      end
      res.v[COMP_W*r +: COMP_W] = COMP_W'(rounded);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vec_t make_vec(input logic [15:0] x, y, z, w);
    return {w, z, y, x};
  endfunction

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'h1000;
    endcase
  endfunction

  function automatic logic [15:0] random_coef(input matrix_kind_t kind);
    case (kind)
      MAT_UNIT:    return 16'(int'($urandom_range(0, 8192)) - 4096);   // within +-1.0
      MAT_EXTREME: return extreme_value();
      MAT_SPARSE:  return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
      default:     return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_component(input vector_kind_t kind);
    case (kind)
      VEC_SMALL:   return 16'(int'($urandom_range(0, 2047)) - 1024);   // within +-4.0
      VEC_EXTREME: return extreme_value();
      default:     return 16'($urandom);
    endcase
  endfunction

  // keeps in_tvalid to a single nonblocking update per time step
  task automatic set_in_valid(input bit v);
    if (in_valid_sched != v) begin
      in_tvalid      <= v;
      in_valid_sched = v;
    end
  endtask

  // one item; bursts of random length with random gaps before each burst
  task automatic send_vector(input vec_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        set_in_valid(1'b0);
        repeat (gap) @(posedge clk);
      end
    end
    set_in_valid(1'b1);
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop sending and wait until every predicted result has come back;
  // wait for the current edge first so an item taken at this edge is already queued
  task automatic wait_drain();
    set_in_valid(1'b0);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // writes all four rows back to back, only ever with the pipe empty
  task automatic apply_matrix(input row_t rows [LANES]);
    wait_drain();
    for (int r = 0; r < LANES; r++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= reg_idx_t'(r);
      cfg_wdata <= rows[r];
      @(posedge clk);
      matrix_rows[r] = rows[r];
    end
    cfg_we <= 1'b0;
    matrices_loaded++;
  endtask

  // coefficient coef on the diagonal, zero elsewhere
  task automatic apply_diagonal(input logic [15:0] coef);
    row_t m [LANES];
    for (int r = 0; r < LANES; r++) m[r] = row_t'(coef) << (COEF_W * r);
    apply_matrix(m);
  endtask

  // same coefficient in all sixteen places
  task automatic apply_uniform(input logic [15:0] coef);
    row_t m [LANES];
    for (int r = 0; r < LANES; r++) m[r] = {LANES{coef}};
    apply_matrix(m);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset matrix is the identity: vectors come back untouched, never clipped
  task automatic test_identity();
    send_vector(make_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_vector(make_vec(16'h7fff, 16'h8000, 16'hffff, 16'h0001));
    send_vector(make_vec(16'h8000, 16'h7fff, 16'h0100, 16'hff00));
    send_vector(make_vec(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    send_vector(make_vec(16'hffff, 16'hffff, 16'hffff, 16'hffff));
  endtask

  // smallest coefficient on the diagonal divides by 4096, exposing rounding:
  // exact halves go toward positive infinity, others to nearest
  task automatic test_rounding();
    apply_diagonal(16'h0001);
    send_vector(make_vec(16'd2048, -16'sd2048, 16'd2047, -16'sd2049));
    send_vector(make_vec(16'd6144, -16'sd6144, 16'd4095, -16'sd4097));
    send_vector(make_vec(16'h7fff, 16'h8000, 16'h0001, 16'hffff));
  endtask

  // clamp edges on both sides, lanes clipping independently, extreme matrices
  task automatic test_saturation();
    row_t m [LANES];
    // gain of two: 16383 fits, 16384 clips high, -16384 just fits, -16385 clips low
    apply_diagonal(16'h2000);
    send_vector(make_vec(16'd16383, 16'd16384, -16'sd16384, -16'sd16385));
    send_vector(make_vec(16'd16383, -16'sd16384, 16'h0000, 16'd100));
    // one row per outcome: clip high, clip low, pass at the limit, zero
    m[0] = {LANES{16'h7fff}};
    m[1] = {LANES{16'h8000}};
    m[2] = ROW_TWO_RST;
    m[3] = '0;
    apply_matrix(m);
    send_vector(make_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // most negative coefficients times most negative inputs
    apply_uniform(16'h8000);
    send_vector(make_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vector(make_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vec(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    // zero matrix and the smallest negative coefficient
    apply_uniform(16'h0000);
    send_vector(make_vec(16'h7fff, 16'h8000, 16'h1234, 16'hedcb));
    apply_uniform(16'hffff);
    send_vector(make_vec(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_vector(make_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000));
  endtask

  // random matrices of each kind, random vectors; each phase drains halfway
  // through so the sender also waits out an empty pipe
  task automatic test_random_streams(input int phases, input int per_phase);
    row_t         m [LANES];
    matrix_kind_t mkind;
    vector_kind_t vkind;
    vec_t         v;
    for (int p = 0; p < phases; p++) begin
      mkind = matrix_kind_t'(p % 4);
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < LANES; c++) m[r][COEF_W*c +: COEF_W] = random_coef(mkind);
      end
      apply_matrix(m);
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(0, 3))
          2:       vkind = VEC_SMALL;
          3:       vkind = VEC_EXTREME;
          default: vkind = VEC_FULL;
        endcase
        for (int c = 0; c < LANES; c++) v[COMP_W*c +: COMP_W] = random_component(vkind);
        if (i == per_phase / 2) wait_drain();
        send_vector(v);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: its own stall pattern, switching between steady, choppy and
  // long-blocked stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_STEADY: begin
        out_tready <= 1'b1;
      end
      RX_CHOPPY: begin
        out_tready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        // alternating runs of low and high ready, each of random length; low runs can be longer
        if (rx_run_left == 0) begin
          rx_run_ready = !rx_run_ready;
          rx_run_left  = rx_run_ready ? $urandom_range(1, 12) : $urandom_range(1, 25);
        end else begin
          rx_run_left--;
        end
        out_tready <= rx_run_ready;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // every accepted input item gets its prediction queued
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(transform_vector(in_tdata));
      items_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // every accepted result is compared with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < MSG_LIMIT)
          $display("%0t: result with no item pending, expected nothing, actual %h/%b",
                   $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        expected_res = expected_results.pop_front();
        for (int lane = 0; lane < LANES; lane++) begin
          if (out_tdata[COMP_W*lane +: COMP_W] !== expected_res.v[COMP_W*lane +: COMP_W]) begin
            if (mismatches < MSG_LIMIT)
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time, lane_names[lane],
                       comp_t'(expected_res.v[COMP_W*lane +: COMP_W]),
                       comp_t'(out_tdata[COMP_W*lane +: COMP_W]));
            mismatches++;
          end
        end
        if (out_tuser[0] !== expected_res.clipped) begin
          if (mismatches < MSG_LIMIT)
            $display("%0t: clipped mismatch, expected %b, actual %b",
                     $time, expected_res.clipped, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[0] === 1'b1) clipped_seen++;
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any item moving ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, nothing accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_results.size());
      $display("tb_matrix_vector_transform_4x4_unit: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_rounding();
    test_saturation();
    test_random_streams(8, 104);

    // all items in; let the last results out and give the pipe time to
    // show any stray extra result
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_results.size());
      mismatches++;
    end

    $display("covered identity, rounding halves, clamp edges and random matrices/vectors");
    $display("%0d items over %0d matrix loads, %0d results checked (%0d clipped), %0d errors",
             items_accepted, matrices_loaded, results_checked, clipped_seen, mismatches);
    if (mismatches == 0)
      $display("tb_matrix_vector_transform_4x4_unit: PASS");
    else
      $display("tb_matrix_vector_transform_4x4_unit: FAIL");
    $finish;
  end

endmodule

// ===== matrix_vector_transform_4x4_unit.f =====
rtl/core/mvt_pkg.sv
rtl/core/mvt_mul_stage.sv
rtl/core/mvt_sum_stage.sv
rtl/core/mvt_sat_stage.sv
rtl/core/matrix_vector_transform_4x4_unit.sv
rtl/core/mvt_checker.sv
tb/sv/tb_matrix_vector_transform_4x4_unit.sv
